### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// Needs a clock named clk and an active-low reset named rst_n where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checks a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Checks that a trigger is followed in the next cycle by a consequence.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

### rtl/core/bmm_pkg.sv
// Shared types, register addresses and constants of the banked memory mapper.
// No dependencies; imported by the mapper top level.
package bmm_pkg;

    localparam int RAM_BANKS       = 8;
    localparam int CYCLES_PER_LINE = 114;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_XLATE = 2'd3
    } item_mode_t;

    localparam logic [15:0] ADDR_BANK_MODE = 16'h5100;
    localparam logic [15:0] ADDR_PROTECT0  = 16'h5102;
    localparam logic [15:0] ADDR_PROTECT1  = 16'h5103;
    localparam logic [15:0] ADDR_BANK0     = 16'h5113;
    localparam logic [15:0] ADDR_BANK1     = 16'h5114;
    localparam logic [15:0] ADDR_BANK2     = 16'h5115;
    localparam logic [15:0] ADDR_BANK3     = 16'h5116;
    localparam logic [15:0] ADDR_BANK4     = 16'h5117;
    localparam logic [15:0] ADDR_LINE_CMP  = 16'h5203;
    localparam logic [15:0] ADDR_IRQ_STAT  = 16'h5204;
    localparam logic [15:0] ADDR_FACTOR0   = 16'h5205;
    localparam logic [15:0] ADDR_FACTOR1   = 16'h5206;
    localparam logic [15:0] ADDR_TIMER_LO  = 16'h5209;
    localparam logic [15:0] ADDR_TIMER_HI  = 16'h520A;

    localparam logic [1:0]  PROTECT_KEY0   = 2'h2;
    localparam logic [1:0]  PROTECT_KEY1   = 2'h1;
    localparam logic [7:0]  READ_UNMAPPED  = 8'hFF;
    localparam logic [15:0] LINE_DECREMENT = CYCLES_PER_LINE[15:0];

    typedef logic [6:0] ram_wrap_t [128];

    // Lookup of a 7-bit bank number folded into the RAM size.
    function automatic ram_wrap_t build_ram_wrap();
        ram_wrap_t tbl;
        for (int i = 0; i < 128; i++)
        begin
            tbl[i] = 7'(i % RAM_BANKS);
        end
        return tbl;
    endfunction

    localparam ram_wrap_t RAM_WRAP = build_ram_wrap();

    typedef struct packed {
        logic       is_ram;
        logic [6:0] bank;
        logic       permit;
    } bank_pick_t;

endpackage

### rtl/core/banked_memory_mapper_with_line_irq_top.sv
// Banked program-memory mapper with scanline-compare and countdown interrupts.
// Depends on bmm_pkg and assert_macros.svh.
//
// The block takes one beat per clock while the output does not stall and returns
// exactly one result beat for each input beat, in order. A beat is a register
// write, a register read, a scanline tick or a translation of a CPU address in
// 6000-FFFF to an 8K bank. An accepted beat lands in an input register. When the
// output register is free or its result is taken, the mapper state is read and
// updated by short logic, and the result is loaded into the output register.
// One beat per cycle is sustained while the consumer takes every result. The
// output register may hold a result while a new beat waits in the input register;
// the pair stalls only when both are full and the consumer does not take the
// result. The multiplier product and the countdown subtract sit in that single
// step. irq_level always reflects the interrupt lines after the beat that
// produced the result. ROM bank numbers are returned as 7 bits and must be
// folded to the ROM size by the system; RAM banks are folded to RAM_BANKS
// here. Reset brings bank_mode to 3, the bank registers to FB..FF and all
// other mapper state to zero; there is no clearing pass.
`include "assert_macros.svh"

module banked_memory_mapper_with_line_irq_top
    import bmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic        vblank,
    input  logic        rendering_enabled,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic [1:0]  irq_new_edges,
    output logic        irq_level,
    output logic        maps_valid,
    output logic        bank_is_ram,
    output logic [7:0]  bank_8k,
    output logic        write_permitted
);

    // Input register.
    logic        s1_valid_reg;
    item_mode_t  s1_mode_reg;
    logic [15:0] s1_addr_reg;
    logic [7:0]  s1_data_reg;
    logic        s1_vblank_reg;
    logic        s1_render_reg;

    // Mapper state.
    logic [1:0]  bank_mode_reg,    bank_mode_next;
    logic [1:0]  protect0_reg,     protect0_next;
    logic [1:0]  protect1_reg,     protect1_next;
    logic [7:0]  bank_sel_reg [5];
    logic [7:0]  bank_sel_next [5];
    logic [7:0]  line_cmp_reg,     line_cmp_next;
    logic        line_en_reg,      line_en_next;
    logic        line_pend_reg,    line_pend_next;
    logic        line_held_reg,    line_held_next;
    logic        frame_active_reg, frame_active_next;
    logic [7:0]  line_cnt_reg,     line_cnt_next;
    logic [7:0]  factor0_reg,      factor0_next;
    logic [7:0]  factor1_reg,      factor1_next;
    logic [15:0] cd_reg,           cd_next;
    logic        cd_run_reg,       cd_run_next;
    logic        cd_flag_reg,      cd_flag_next;
    logic        cd_held_reg,      cd_held_next;

    // Result register.
    logic        out_valid_reg;
    logic [7:0]  rd_reg,     rd_next;
    logic [1:0]  edges_reg,  edges_next;
    logic        level_reg;
    logic        mapv_reg,   mapv_next;
    logic        isram_reg,  isram_next;
    logic [6:0]  bank_reg,   bank_next;
    logic        permit_reg, permit_next;

    logic        advance;
    logic        writable;
    logic [15:0] product;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign writable = (protect0_reg == PROTECT_KEY0) && (protect1_reg == PROTECT_KEY1);
    assign product  = factor0_reg * factor1_reg;

    // A selecting register with bit 7 set picks ROM, otherwise a RAM bank.
    function automatic bank_pick_t pick(input logic [7:0] v, input logic wr);
        bank_pick_t p;
        p.is_ram = !v[7];
        p.bank   = v[7] ? v[6:0] : RAM_WRAP[v[6:0]];
        p.permit = !v[7] && wr;
        return p;
    endfunction

    function automatic bank_pick_t rom(input logic [6:0] b);
        bank_pick_t p;
        p.is_ram = 1'b0;
        p.bank   = b;
        p.permit = 1'b0;
        return p;
    endfunction

    always_comb
    begin
        logic [1:0]  q;
        logic [7:0]  s2;
        bank_pick_t  sel;
        logic [1:0]  edges;
        logic        rendering;

        bank_mode_next    = bank_mode_reg;
        protect0_next     = protect0_reg;
        protect1_next     = protect1_reg;
        bank_sel_next     = bank_sel_reg;
        line_cmp_next     = line_cmp_reg;
        line_en_next      = line_en_reg;
        line_pend_next    = line_pend_reg;
        line_held_next    = line_held_reg;
        frame_active_next = frame_active_reg;
        line_cnt_next     = line_cnt_reg;
        factor0_next      = factor0_reg;
        factor1_next      = factor1_reg;
        cd_next           = cd_reg;
        cd_run_next       = cd_run_reg;
        cd_flag_next      = cd_flag_reg;
        cd_held_next      = cd_held_reg;

        rd_next     = 8'h00;
        edges_next  = 2'd0;
        mapv_next   = 1'b0;
        isram_next  = 1'b0;
        bank_next   = 7'd0;
        permit_next = 1'b0;

        q         = s1_addr_reg[14:13];
        s2        = bank_sel_reg[2];
        sel       = '0;
        edges     = 2'd0;
        rendering = !s1_vblank_reg && s1_render_reg;

        unique case (s1_mode_reg)
            MODE_WRITE:
            begin
                unique case (s1_addr_reg)
                    ADDR_BANK_MODE: bank_mode_next   = s1_data_reg[1:0];
                    ADDR_PROTECT0:  protect0_next    = s1_data_reg[1:0];
                    ADDR_PROTECT1:  protect1_next    = s1_data_reg[1:0];
                    ADDR_BANK0:     bank_sel_next[0] = s1_data_reg;
                    ADDR_BANK1:     bank_sel_next[1] = s1_data_reg;
                    ADDR_BANK2:     bank_sel_next[2] = s1_data_reg;
                    ADDR_BANK3:     bank_sel_next[3] = s1_data_reg;
                    ADDR_BANK4:     bank_sel_next[4] = s1_data_reg;
                    ADDR_LINE_CMP:  line_cmp_next    = s1_data_reg;
                    ADDR_IRQ_STAT:
                    begin
                        line_en_next = s1_data_reg[7];
                        if (!s1_data_reg[7])
                        begin
                            line_pend_next = 1'b0;
                            line_held_next = 1'b0;
                        end
                    end
                    ADDR_FACTOR0:   factor0_next     = s1_data_reg;
                    ADDR_FACTOR1:   factor1_next     = s1_data_reg;
                    ADDR_TIMER_LO:
                    begin
                        cd_next     = {cd_reg[15:8], s1_data_reg};
                        cd_run_next = 1'b1;
                    end
                    ADDR_TIMER_HI:  cd_next          = {s1_data_reg, cd_reg[7:0]};
                    default:        ;
                endcase
            end
            MODE_READ:
            begin
                unique case (s1_addr_reg)
                    ADDR_IRQ_STAT:
                    begin
                        rd_next        = {line_pend_reg, frame_active_reg, 6'd0};
                        line_pend_next = 1'b0;
                        line_held_next = 1'b0;
                    end
                    ADDR_FACTOR0:  rd_next = product[7:0];
                    ADDR_FACTOR1:  rd_next = product[15:8];
                    ADDR_TIMER_LO:
                    begin
                        rd_next      = {cd_flag_reg, 7'd0};
                        cd_flag_next = 1'b0;
                        cd_held_next = 1'b0;
                    end
                    default:       rd_next = READ_UNMAPPED;
                endcase
            end
            MODE_TICK:
            begin
                if (!rendering)
                begin
                    frame_active_next = 1'b0;
                    line_held_next    = 1'b0;
                    cd_held_next      = 1'b0;
                end
                else if (!frame_active_reg)
                begin
                    frame_active_next = 1'b1;
                    line_cnt_next     = 8'd0;
                    line_pend_next    = 1'b0;
                    line_held_next    = 1'b0;
                end
                else
                begin
                    line_cnt_next = line_cnt_reg + 8'd1;
                end
                // The compare looks at the counter and frame flag after the update.
                if ((line_cmp_reg != 8'd0) && (line_cnt_next == line_cmp_reg)
                    && frame_active_next)
                begin
                    line_pend_next = 1'b1;
                    if (line_en_reg && !line_held_next)
                    begin
                        line_held_next = 1'b1;
                        edges          = edges + 2'd1;
                    end
                end
                if (cd_run_reg && (cd_reg != 16'd0))
                begin
                    if (cd_reg > LINE_DECREMENT)
                    begin
                        cd_next = cd_reg - LINE_DECREMENT;
                    end
                    else
                    begin
                        cd_next      = 16'd0;
                        cd_flag_next = 1'b1;
                        if (!cd_held_next)
                        begin
                            cd_held_next = 1'b1;
                            edges        = edges + 2'd1;
                        end
                    end
                end
                edges_next = edges;
            end
            MODE_XLATE:
            begin
                if (s1_addr_reg[15] || (q == 2'd3))
                begin
                    if (!s1_addr_reg[15])
                    begin
                        sel = '{is_ram: 1'b1, bank: RAM_WRAP[bank_sel_reg[0][6:0]],
                                permit: writable};
                    end
                    else
                    begin
                        unique case (bank_mode_reg)
                            2'd0:
                                sel = rom({bank_sel_reg[4][6:2], q});
                            2'd1:
                                unique case (q)
                                    2'd0:    sel = pick({s2[7:1], 1'b0}, writable);
                                    2'd1:    sel = pick({s2[7:1], 1'b1}, writable);
                                    default: sel = rom({bank_sel_reg[4][6:1], q[0]});
                                endcase
                            2'd2:
                                unique case (q)
                                    2'd0: sel = pick({s2[7:1], 1'b0}, writable);
                                    2'd1: sel = pick({s2[7:1], 1'b1}, writable);
                                    2'd2: sel = pick(bank_sel_reg[3], writable);
                                    2'd3: sel = rom(bank_sel_reg[4][6:0]);
                                endcase
                            2'd3:
                                unique case (q)
                                    2'd0: sel = pick(bank_sel_reg[1], writable);
                                    2'd1: sel = pick(bank_sel_reg[2], writable);
                                    2'd2: sel = pick(bank_sel_reg[3], writable);
                                    2'd3: sel = rom(bank_sel_reg[4][6:0]);
                                endcase
                        endcase
                    end
                    mapv_next   = 1'b1;
                    isram_next  = sel.is_ram;
                    bank_next   = sel.bank;
                    permit_next = sel.permit;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            bank_mode_reg    <= 2'd3;
            protect0_reg     <= 2'd0;
            protect1_reg     <= 2'd0;
            bank_sel_reg     <= '{8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF};
            line_cmp_reg     <= 8'd0;
            line_en_reg      <= 1'b0;
            line_pend_reg    <= 1'b0;
            line_held_reg    <= 1'b0;
            frame_active_reg <= 1'b0;
            line_cnt_reg     <= 8'd0;
            factor0_reg      <= 8'd0;
            factor1_reg      <= 8'd0;
            cd_reg           <= 16'd0;
            cd_run_reg       <= 1'b0;
            cd_flag_reg      <= 1'b0;
            cd_held_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                bank_mode_reg    <= bank_mode_next;
                protect0_reg     <= protect0_next;
                protect1_reg     <= protect1_next;
                bank_sel_reg     <= bank_sel_next;
                line_cmp_reg     <= line_cmp_next;
                line_en_reg      <= line_en_next;
                line_pend_reg    <= line_pend_next;
                line_held_reg    <= line_held_next;
                frame_active_reg <= frame_active_next;
                line_cnt_reg     <= line_cnt_next;
                factor0_reg      <= factor0_next;
                factor1_reg      <= factor1_next;
                cd_reg           <= cd_next;
                cd_run_reg       <= cd_run_next;
                cd_flag_reg      <= cd_flag_next;
                cd_held_reg      <= cd_held_next;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_mode_reg   <= item_mode_t'(mode);
            s1_addr_reg   <= address;
            s1_data_reg   <= write_data;
            s1_vblank_reg <= vblank;
            s1_render_reg <= rendering_enabled;
        end
        if (advance)
        begin
            rd_reg     <= rd_next;
            edges_reg  <= edges_next;
            level_reg  <= line_held_next | cd_held_next;
            mapv_reg   <= mapv_next;
            isram_reg  <= isram_next;
            bank_reg   <= bank_next;
            permit_reg <= permit_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = rd_reg;
    assign irq_new_edges   = edges_reg;
    assign irq_level       = level_reg;
    assign maps_valid      = mapv_reg;
    assign bank_is_ram     = isram_reg;
    assign bank_8k         = {1'b0, bank_reg};
    assign write_permitted = permit_reg;

    `ASSERT_ALWAYS(a_level_tracks_state,
        !out_valid_reg || (level_reg == (line_held_reg | cd_held_reg)),
        "irq_level disagrees with the held interrupt lines")
    `ASSERT_ALWAYS(a_edges_bounded, !out_valid_reg || (edges_reg != 2'd3),
        "more than two interrupt edges reported for one beat")
    `ASSERT_NEXT(a_timer_read_clears,
        advance && (s1_mode_reg == MODE_READ) && (s1_addr_reg == ADDR_TIMER_LO),
        !cd_held_reg && !cd_flag_reg,
        "countdown flag survived a status read")
    `ASSERT_NEXT(a_state_frozen_on_stall, !advance,
        $stable(cd_reg) && $stable(line_cnt_reg) && $stable(line_held_reg),
        "mapper state changed without a beat being processed")

endmodule

### sim/tb_banked_memory_mapper_with_line_irq_top.sv
// Self-checking testbench for the banked memory mapper with scanline and countdown interrupts.
// Depends on bmm_pkg and the mapper top level; a scoreboard class predicts every result beat.
module tb_banked_memory_mapper_with_line_irq_top
    import bmm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // The run is short; this limit sits far above the slowest legal run.
    localparam int LIMIT_CYCLES   = 200000;
    localparam int BULK_ITEMS     = 850;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 16;

    // Program windows decoded by the mapper.
    localparam logic [15:0] WINDOW_RAM_BASE = 16'h6000;
    localparam logic [15:0] WINDOW_ROM_BASE = 16'h8000;

    // 8K slots inside the 8000-FFFF window.
    localparam logic [1:0] SLOT_8000 = 2'd0;
    localparam logic [1:0] SLOT_A000 = 2'd1;
    localparam logic [1:0] SLOT_C000 = 2'd2;
    localparam logic [1:0] SLOT_E000 = 2'd3;

    // Program bank layouts selected by the bank mode register.
    typedef enum logic [1:0] {
        PRG_32K    = 2'd0,
        PRG_16K    = 2'd1,
        PRG_16K_8K = 2'd2,
        PRG_8K     = 2'd3
    } prg_layout_t;

    // The mapping registers come first so that bank setup can draw from the head of the list.
    localparam logic [15:0] REG_ADDRS [14] = '{
        ADDR_BANK_MODE, ADDR_PROTECT0, ADDR_PROTECT1, ADDR_BANK0, ADDR_BANK1, ADDR_BANK2,
        ADDR_BANK3, ADDR_BANK4, ADDR_LINE_CMP, ADDR_IRQ_STAT, ADDR_FACTOR0, ADDR_FACTOR1,
        ADDR_TIMER_LO, ADDR_TIMER_HI
    };

    typedef struct {
        item_mode_t  mode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        vblank;
        logic        rendering_enabled;
    } mapper_beat_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] irq_new_edges;
        logic       irq_level;
        logic       maps_valid;
        logic       bank_is_ram;
        logic [7:0] bank_8k;
        logic       write_permitted;
    } mapper_result_t;

    // The scoreboard keeps its own copy of the mapper state. Every accepted input beat is run
    // through it at once, and the predicted result waits in order for the matching output beat.
    class mapper_scoreboard;
        mapper_result_t expected_results [$];
        int             failures;

        prg_layout_t layout;
        logic [1:0]  protect [2];
        logic [7:0]  bank_sel [5];
        logic [7:0]  line_cmp;
        logic        line_en;
        logic        line_pend;
        logic        line_held;
        logic        frame_active;
        logic [7:0]  line_cnt;
        logic [7:0]  factor [2];
        logic [15:0] countdown;
        logic        cd_running;
        logic        cd_flag;
        logic        cd_held;

        function new();
            failures     = 0;
            layout       = PRG_8K;
            protect[0]   = 2'd0;
            protect[1]   = 2'd0;
            bank_sel     = '{8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF};
            line_cmp     = 8'd0;
            line_en      = 1'b0;
            line_pend    = 1'b0;
            line_held    = 1'b0;
            frame_active = 1'b0;
            line_cnt     = 8'd0;
            factor[0]    = 8'd0;
            factor[1]    = 8'd0;
            countdown    = 16'd0;
            cd_running   = 1'b0;
            cd_flag      = 1'b0;
            cd_held      = 1'b0;
        endfunction

        function bit ram_writable();
            return protect[0] == PROTECT_KEY0 && protect[1] == PROTECT_KEY1;
        endfunction

        function logic [7:0] ram_page(logic [7:0] v);
            return 8'((v & 8'h7F) % RAM_BANKS);
        endfunction

        function void rom_bank(logic [7:0] v, inout mapper_result_t r);
            r.bank_is_ram     = 1'b0;
            r.bank_8k         = v & 8'h7F;
            r.write_permitted = 1'b0;
        endfunction

        // Bit 7 of a selecting register picks ROM; otherwise the value names a RAM page.
        function void select_bank(logic [7:0] v, inout mapper_result_t r);
            if (v[7])
            begin
                rom_bank(v, r);
            end
            else
            begin
                r.bank_is_ram     = 1'b1;
                r.bank_8k         = ram_page(v);
                r.write_permitted = ram_writable();
            end
        endfunction

        function mapper_result_t next_mapper_result(mapper_beat_t b);
            mapper_result_t r;
            logic [15:0]    product;
            logic [1:0]     slot;
            r = '0;
            product = 16'(factor[0]) * 16'(factor[1]);
            case (b.mode)
                MODE_WRITE:
                begin
                    case (b.address)
                        ADDR_BANK_MODE: layout = prg_layout_t'(b.write_data[1:0]);
                        ADDR_PROTECT0:  protect[0] = b.write_data[1:0];
                        ADDR_PROTECT1:  protect[1] = b.write_data[1:0];
                        ADDR_BANK0, ADDR_BANK1, ADDR_BANK2, ADDR_BANK3, ADDR_BANK4:
                            bank_sel[int'(b.address - ADDR_BANK0)] = b.write_data;
                        ADDR_LINE_CMP:  line_cmp = b.write_data;
                        ADDR_IRQ_STAT:
                        begin
                            line_en = b.write_data[7];
                            if (!line_en)
                            begin
                                line_pend = 1'b0;
                                line_held = 1'b0;
                            end
                        end
                        ADDR_FACTOR0:   factor[0] = b.write_data;
                        ADDR_FACTOR1:   factor[1] = b.write_data;
                        ADDR_TIMER_LO:
                        begin
                            countdown[7:0] = b.write_data;
                            cd_running     = 1'b1;
                        end
                        ADDR_TIMER_HI:  countdown[15:8] = b.write_data;
                        default:        ;
                    endcase
                end
                MODE_READ:
                begin
                    case (b.address)
                        ADDR_IRQ_STAT:
                        begin
                            r.read_data = {line_pend, frame_active, 6'd0};
                            line_pend   = 1'b0;
                            line_held   = 1'b0;
                        end
                        ADDR_FACTOR0:  r.read_data = product[7:0];
                        ADDR_FACTOR1:  r.read_data = product[15:8];
                        ADDR_TIMER_LO:
                        begin
                            r.read_data = {cd_flag, 7'd0};
                            cd_flag     = 1'b0;
                            cd_held     = 1'b0;
                        end
                        default:       r.read_data = READ_UNMAPPED;
                    endcase
                end
                MODE_TICK:
                begin
                    if (b.vblank || !b.rendering_enabled)
                    begin
                        frame_active = 1'b0;
                        line_held    = 1'b0;
                        cd_held      = 1'b0;
                    end
                    else if (!frame_active)
                    begin
                        frame_active = 1'b1;
                        line_cnt     = 8'd0;
                        line_pend    = 1'b0;
                        line_held    = 1'b0;
                    end
                    else
                    begin
                        line_cnt = line_cnt + 8'd1;
                    end
                    if (line_cmp != 8'd0 && line_cnt == line_cmp && frame_active)
                    begin
                        line_pend = 1'b1;
                        if (line_en && !line_held)
                        begin
                            line_held       = 1'b1;
                            r.irq_new_edges = r.irq_new_edges + 2'd1;
                        end
                    end
                    if (cd_running && countdown != 16'd0)
                    begin
                        if (countdown > 16'(CYCLES_PER_LINE))
                        begin
                            countdown = countdown - 16'(CYCLES_PER_LINE);
                        end
                        else
                        begin
                            countdown = 16'd0;
                            cd_flag   = 1'b1;
                            if (!cd_held)
                            begin
                                cd_held         = 1'b1;
                                r.irq_new_edges = r.irq_new_edges + 2'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    if (b.address >= WINDOW_RAM_BASE)
                    begin
                        r.maps_valid = 1'b1;
                        slot = b.address[14:13];
                        if (b.address < WINDOW_ROM_BASE)
                        begin
                            // The 6000 window is always work RAM, whatever bit 7 says.
                            r.bank_is_ram     = 1'b1;
                            r.bank_8k         = ram_page(bank_sel[0]);
                            r.write_permitted = ram_writable();
                        end
                        else
                        begin
                            case (layout)
                                PRG_32K:
                                    rom_bank((bank_sel[4] & 8'h7C) | {6'd0, slot}, r);
                                PRG_16K:
                                begin
                                    if (slot == SLOT_8000)
                                        select_bank(bank_sel[2] & 8'hFE, r);
                                    else if (slot == SLOT_A000)
                                        select_bank(bank_sel[2] | 8'h01, r);
                                    else
                                        rom_bank((bank_sel[4] & 8'h7E) | {7'd0, slot[0]}, r);
                                end
                                PRG_16K_8K:
                                begin
                                    if (slot == SLOT_8000)
                                        select_bank(bank_sel[2] & 8'hFE, r);
                                    else if (slot == SLOT_A000)
                                        select_bank(bank_sel[2] | 8'h01, r);
                                    else if (slot == SLOT_C000)
                                        select_bank(bank_sel[3], r);
                                    else
                                        rom_bank(bank_sel[4], r);
                                end
                                default:
                                begin
                                    if (slot == SLOT_E000)
                                        rom_bank(bank_sel[4], r);
                                    else
                                        select_bank(bank_sel[int'(slot) + 1], r);
                                end
                            endcase
                        end
                    end
                end
            endcase
            r.irq_level = line_held | cd_held;
            return r;
        endfunction

        function void note_beat(mapper_beat_t b);
            expected_results.push_back(next_mapper_result(b));
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(mapper_result_t got);
            mapper_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result beat arrived with no prediction waiting");
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("read_data", want.read_data, got.read_data);
                compare_field("irq_new_edges", 8'(want.irq_new_edges), 8'(got.irq_new_edges));
                compare_field("irq_level", 8'(want.irq_level), 8'(got.irq_level));
                compare_field("maps_valid", 8'(want.maps_valid), 8'(got.maps_valid));
                compare_field("bank_is_ram", 8'(want.bank_is_ram), 8'(got.bank_is_ram));
                compare_field("bank_8k", want.bank_8k, got.bank_8k);
                compare_field("write_permitted", 8'(want.write_permitted),
                              8'(got.write_permitted));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        vblank;
    logic        rendering_enabled;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;
    logic [1:0]  irq_new_edges;
    logic        irq_level;
    logic        maps_valid;
    logic        bank_is_ram;
    logic [7:0]  bank_8k;
    logic        write_permitted;

    mapper_scoreboard sb;
    int               burst_left;
    int               items_sent;
    int               cycle_count;
    bit               bulk_phase;

    banked_memory_mapper_with_line_irq_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .address           (address),
        .write_data        (write_data),
        .vblank            (vblank),
        .rendering_enabled (rendering_enabled),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .read_data         (read_data),
        .irq_new_edges     (irq_new_edges),
        .irq_level         (irq_level),
        .maps_valid        (maps_valid),
        .bank_is_ram       (bank_is_ram),
        .bank_8k           (bank_8k),
        .write_permitted   (write_permitted)
    );

    // 8 ns clock, starting low.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offers one beat. It is entered just after a falling edge and returns just after the
    // falling edge that follows acceptance, so back-to-back beats keep in_valid high without a
    // second assignment in the same step. The sender works in bursts; a gap of idle cycles is
    // inserted in most cases when a burst runs out.
    task automatic send_beat(input item_mode_t m, input logic [15:0] a, input logic [7:0] d,
                             input logic vb, input logic ren);
        mapper_beat_t b;
        int           gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            // Now and then a long burst gives a stretch with no sender idling at all.
            burst_left = ($urandom_range(0, 9) == 0) ? 64 : int'($urandom_range(1, 16));
        end
        burst_left--;
        b.mode              = m;
        b.address           = a;
        b.write_data        = d;
        b.vblank            = vb;
        b.rendering_enabled = ren;
        in_valid          <= 1'b1;
        mode              <= m;
        address           <= a;
        write_data        <= d;
        vblank            <= vb;
        rendering_enabled <= ren;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_beat(b);
        items_sent++;
        @(negedge clk);
    endtask

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(mapper_result_t'({read_data, irq_new_edges, irq_level, maps_valid,
                                              bank_is_ram, bank_8k, write_permitted}));
        end
    end

    // The receiver changes its stall rate in stretches of random length, from never stalling
    // to stalling most cycles. Once the bulk traffic starts it refuses results for a long
    // stretch so that the output and input registers fill and in_ready drops.
    initial
    begin
        int stall_pct;
        int stretch_left;
        int hold_left;
        bit hold_done;
        stall_pct    = 0;
        stretch_left = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (stretch_left == 0)
            begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 85;
                endcase
                stretch_left = $urandom_range(16, 80);
            end
            stretch_left--;
            if (bulk_phase && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_banked_memory_mapper_with_line_irq_top: FAIL");
        $finish;
    end

    initial
    begin
        int          target;
        int          lines;
        int          k;
        int          r;
        int          pick;
        int          n;
        bit          long_frame;
        logic [7:0]  cmp;
        logic [7:0]  d;
        logic [15:0] a;
        logic [15:0] tval;

        sb         = new();
        burst_left = 0;
        items_sent = 0;
        bulk_phase <= 1'b0;
        in_valid          <= 1'b0;
        mode              <= MODE_WRITE;
        address           <= 16'd0;
        write_data        <= 8'd0;
        vblank            <= 1'b0;
        rendering_enabled <= 1'b0;
        rst_n             <= 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Reset values first: idle status and an unlisted read.
        send_beat(MODE_READ, ADDR_IRQ_STAT, 8'h00, 1'b0, 1'b0);
        send_beat(MODE_READ, 16'h0000, 8'h00, 1'b0, 1'b0);
        // Window edges with the reset bank registers: just below, RAM window, top of ROM.
        send_beat(MODE_XLATE, 16'h5FFF, 8'h00, 1'b0, 1'b0);
        send_beat(MODE_XLATE, WINDOW_RAM_BASE, 8'h00, 1'b0, 1'b0);
        send_beat(MODE_XLATE, 16'hFFFF, 8'h00, 1'b0, 1'b0);
        // Largest product, both bytes.
        send_beat(MODE_WRITE, ADDR_FACTOR0, 8'hFF, 1'b0, 1'b0);
        send_beat(MODE_WRITE, ADDR_FACTOR1, 8'hFF, 1'b0, 1'b0);
        send_beat(MODE_READ, ADDR_FACTOR0, 8'h00, 1'b0, 1'b0);
        send_beat(MODE_READ, ADDR_FACTOR1, 8'h00, 1'b0, 1'b0);
        // Unlock RAM writes (upper bits of the data must be masked) and map RAM page 0.
        send_beat(MODE_WRITE, ADDR_PROTECT0, 8'hFE, 1'b0, 1'b0);
        send_beat(MODE_WRITE, ADDR_PROTECT1, 8'h01, 1'b0, 1'b0);
        send_beat(MODE_WRITE, ADDR_BANK1, 8'h00, 1'b0, 1'b0);
        send_beat(MODE_XLATE, WINDOW_ROM_BASE, 8'h00, 1'b0, 1'b0);
        // One 32K ROM bank: the slot number fills the low bits.
        send_beat(MODE_WRITE, ADDR_BANK_MODE, 8'h00, 1'b0, 1'b0);
        send_beat(MODE_XLATE, 16'hE000, 8'h00, 1'b0, 1'b0);
        // Scanline compare on line 1 with the interrupt enabled.
        send_beat(MODE_WRITE, ADDR_LINE_CMP, 8'h01, 1'b0, 1'b0);
        send_beat(MODE_WRITE, ADDR_IRQ_STAT, 8'h80, 1'b0, 1'b0);
        send_beat(MODE_TICK, 16'h0000, 8'h00, 1'b0, 1'b1);
        send_beat(MODE_TICK, 16'h0000, 8'h00, 1'b0, 1'b1);
        send_beat(MODE_READ, ADDR_IRQ_STAT, 8'h00, 1'b0, 1'b0);
        // Countdown of exactly one line's worth runs out on the next tick.
        send_beat(MODE_WRITE, ADDR_TIMER_LO, 8'(CYCLES_PER_LINE), 1'b0, 1'b0);
        send_beat(MODE_TICK, 16'h0000, 8'h00, 1'b0, 1'b1);
        send_beat(MODE_READ, ADDR_TIMER_LO, 8'h00, 1'b0, 1'b0);
        // Vertical blank leaves the frame; a write to an unlisted address is ignored.
        send_beat(MODE_TICK, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        send_beat(MODE_WRITE, 16'hFFFF, 8'hFF, 1'b0, 1'b0);

        // Bulk traffic: mostly whole frames and bank setups with random content, some noise.
        bulk_phase <= 1'b1;
        target = items_sent + BULK_ITEMS;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // One frame: compare value, enable, optional countdown, rendered lines and
                // status reads, then vertical blank. A rare long frame wraps the line counter.
                long_frame = ($urandom_range(0, 40) == 0);
                lines = long_frame ? 260 : int'($urandom_range(2, 14));
                if (long_frame)
                    cmp = 8'hFF;
                else if ($urandom_range(0, 9) == 0)
                    cmp = 8'($urandom);
                else
                    cmp = 8'($urandom_range(1, 8));
                send_beat(MODE_WRITE, ADDR_LINE_CMP, cmp, 1'b0, 1'b0);
                d = 8'($urandom);
                d[7] = ($urandom_range(0, 3) != 0);
                send_beat(MODE_WRITE, ADDR_IRQ_STAT, d, 1'b0, 1'b0);
                if ($urandom_range(0, 1) == 1)
                begin
                    // Half the loads run out on the compare line, so both edges can coincide.
                    if ($urandom_range(0, 1) == 1)
                        tval = 16'(CYCLES_PER_LINE * (int'(cmp) + 1) - $urandom_range(0, 113));
                    else
                        tval = {($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 2)),
                                8'($urandom)};
                    send_beat(MODE_WRITE, ADDR_TIMER_HI, tval[15:8], 1'b0, 1'b0);
                    send_beat(MODE_WRITE, ADDR_TIMER_LO, tval[7:0], 1'b0, 1'b0);
                end
                for (k = 0; k < lines; k++)
                begin
                    r = long_frame ? 15 : int'($urandom_range(0, 15));
                    a = 16'($urandom);
                    d = 8'($urandom);
                    if (r == 0)
                        send_beat(MODE_READ, ADDR_IRQ_STAT, d, 1'b0, 1'b0);
                    else if (r == 1)
                        send_beat(MODE_READ, ADDR_TIMER_LO, d, 1'b0, 1'b0);
                    else if (r == 2)
                        send_beat(MODE_TICK, a, d, 1'($urandom), 1'($urandom));
                    else
                        send_beat(MODE_TICK, a, d, 1'b0, 1'b1);
                end
                send_beat(MODE_TICK, 16'($urandom), 8'($urandom), 1'b1, 1'($urandom));
            end
            else if (pick < 70)
            begin
                // Bank setup followed by translations, biased into the program windows.
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                begin
                    a = REG_ADDRS[$urandom_range(0, 7)];
                    d = 8'($urandom);
                    if (a == ADDR_PROTECT0 && $urandom_range(0, 1) == 1)
                        d[1:0] = PROTECT_KEY0;
                    if (a == ADDR_PROTECT1 && $urandom_range(0, 1) == 1)
                        d[1:0] = PROTECT_KEY1;
                    send_beat(MODE_WRITE, a, d, 1'b0, 1'b0);
                end
                n = $urandom_range(2, 8);
                for (k = 0; k < n; k++)
                begin
                    case ($urandom_range(0, 9))
                        0:       a = 16'($urandom);
                        1:       a = ($urandom_range(0, 1) == 1) ? 16'h5FFF : 16'h7FFF;
                        default: a = {3'($urandom_range(3, 7)), 13'($urandom)};
                    endcase
                    send_beat(MODE_XLATE, a, 8'($urandom), 1'($urandom), 1'($urandom));
                end
            end
            else if (pick < 80)
            begin
                send_beat(MODE_WRITE, ADDR_FACTOR0, 8'($urandom), 1'b0, 1'b0);
                send_beat(MODE_WRITE, ADDR_FACTOR1, 8'($urandom), 1'b0, 1'b0);
                if ($urandom_range(0, 1) == 1)
                begin
                    send_beat(MODE_READ, ADDR_FACTOR1, 8'h00, 1'b0, 1'b0);
                    send_beat(MODE_READ, ADDR_FACTOR0, 8'h00, 1'b0, 1'b0);
                end
                else
                begin
                    send_beat(MODE_READ, ADDR_FACTOR0, 8'h00, 1'b0, 1'b0);
                    send_beat(MODE_READ, ADDR_FACTOR1, 8'h00, 1'b0, 1'b0);
                end
            end
            else
            begin
                // Noise: any kind of beat, at random addresses or next to real registers.
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 1) == 1)
                        a = 16'($urandom);
                    else
                        a = REG_ADDRS[$urandom_range(0, 13)] + 16'($urandom_range(0, 2)) - 16'd1;
                    send_beat(item_mode_t'($urandom_range(0, 3)), a, 8'($urandom),
                              1'($urandom), 1'($urandom));
                end
            end
        end
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        // A few more cycles catch any result beat that has no prediction behind it.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("tb_banked_memory_mapper_with_line_irq_top: PASS");
        else
            $display("tb_banked_memory_mapper_with_line_irq_top: FAIL");
        $finish;
    end

endmodule
